FILE: sv/fha_pkg.sv
// ----------------------------------------------------------------------------
// fha_pkg
// Shared types and codes for the heap block allocator.
// ----------------------------------------------------------------------------
package fha_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [12:0] request_size;
        logic [11:0] payload_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] granted_offset;
        logic [12:0] granted_size;
    } t_rsp;

endpackage

FILE: sv/fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// fit_heap_allocator
// Address-ordered block table allocator, first or best fit, split and merge.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  in       | input     | i_in_valid / o_in_ready / i_in_data (t_req)
//  out      | output    | o_out_valid / i_out_ready / o_out_data (t_rsp)
//  cfg      | input     | i_cfg_valid / o_cfg_ready / i_cfg_data (fit_mode)
//
// One request at a time. The table sits in a memory with a registered read
// port; scan and shift visit each entry in a read state and then a check or
// write state. After reset the S_INIT state writes the initial entry before
// the first transaction. A request is taken while a previous result still
// waits at the output.
// ----------------------------------------------------------------------------
module fit_heap_allocator
    import fha_pkg::*;
#(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int SW = ((AW > 13) ? AW : 13) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = IW + 1;
    localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_SC_RD  = 5'd2;
    localparam logic [4:0] S_SC_CHK = 5'd3;
    localparam logic [4:0] S_A_DEC  = 5'd4;
    localparam logic [4:0] S_SHU_RD = 5'd5;
    localparam logic [4:0] S_SHU_WR = 5'd6;
    localparam logic [4:0] S_A_WR   = 5'd7;
    localparam logic [4:0] S_A_WR2  = 5'd8;
    localparam logic [4:0] S_FN_RD  = 5'd9;
    localparam logic [4:0] S_FN_CHK = 5'd10;
    localparam logic [4:0] S_FP_RD  = 5'd11;
    localparam logic [4:0] S_FP_CHK = 5'd12;
    localparam logic [4:0] S_F_MRG  = 5'd13;
    localparam logic [4:0] S_SHD_RD = 5'd14;
    localparam logic [4:0] S_SHD_WR = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;

    typedef struct packed {
        logic          free;
        logic [AW-1:0] size;
        logic [AW-1:0] addr;
    } t_ent;

    t_ent r_mem [MAX_BLOCKS];
    t_ent r_rd;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_pick, n_pick;
    logic [1:0]    r_rm, n_rm;
    logic          r_fit, r_found, n_found, r_split, n_split, r_nf, n_nf, r_pf, n_pf;
    t_req          r_req, n_req;
    t_ent          r_pe, n_pe, r_ne, n_ne, r_pv, n_pv;
    t_rsp          r_res, n_res, r_out, n_out;
    logic          r_ov, n_ov;

    logic          we;
    logic [IW-1:0] wa, ra;
    t_ent          wd;

    logic [SW-1:0] req_w, size_w, pick_hdr, need, merged, merged_p;
    logic [CW-1:0] pick_p1;
    logic          hit;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        req_w    = SW'(r_req.request_size);
        size_w   = SW'(r_rd.size);
        pick_hdr = SW'(r_pe.addr) + HDR;
        need     = req_w + HDR;
        pick_p1  = CW'(r_pick) + CW'(1);
        merged   = SW'(r_pe.size) + (r_nf ? (HDR + SW'(r_ne.size)) : SW'(0));
        merged_p = SW'(r_pv.size) + HDR + merged;
        if (r_req.operation == OP_ALLOC) begin
            hit = r_rd.free && (size_w >= req_w);
        end else begin
            hit = !r_rd.free &&
                  ((SW'(r_rd.addr) + HDR) == SW'(r_req.payload_offset));
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_pick  = r_pick;
        n_rm    = r_rm;
        n_found = r_found;
        n_split = r_split;
        n_nf    = r_nf;
        n_pf    = r_pf;
        n_req   = r_req;
        n_pe    = r_pe;
        n_ne    = r_ne;
        n_pv    = r_pv;
        n_res   = r_res;
        n_out   = r_out;
        n_ov    = r_ov && !i_out_ready;
        we      = 1'b0;
        wa      = '0;
        wd      = '0;
        ra      = r_idx[IW-1:0];

        unique case (r_state)
            S_INIT: begin
                we      = 1'b1;
                wa      = '0;
                wd.free = 1'b1;
                wd.size = AW'(HEAP_BYTES - HEADER_BYTES);
                wd.addr = '0;
                n_cnt   = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                n_idx   = r_idx + CW'(1);
                n_state = (r_idx + CW'(1) == r_cnt) ?
                          ((r_req.operation == OP_ALLOC) ? S_A_DEC : S_DONE) : S_SC_RD;
                if (r_req.operation == OP_ALLOC) begin
                    if (hit && (!r_found || (r_fit && r_rd.size < r_pe.size))) begin
                        n_pick  = r_idx[IW-1:0];
                        n_pe    = r_rd;
                        n_found = 1'b1;
                    end
                    if (hit && !r_fit) begin
                        n_state = S_A_DEC;
                    end
                end else if (hit) begin
                    n_pick  = r_idx[IW-1:0];
                    n_pe    = r_rd;
                    n_state = S_FN_RD;
                end
                n_res = '{status: ST_BAD_FREE, granted_offset: '0, granted_size: '0};
            end
            S_A_DEC: begin
                if (!r_found) begin
                    n_res   = '{status: ST_NO_FIT, granted_offset: '0, granted_size: '0};
                    n_state = S_DONE;
                end else begin
                    n_split = (SW'(r_pe.size) > need) && (r_cnt < MAXC);
                    n_idx   = r_cnt;
                    n_state = ((SW'(r_pe.size) > need) && (r_cnt < MAXC)) ? S_SHU_RD : S_A_WR;
                end
            end
            S_SHU_RD: begin
                ra = IW'(r_idx - CW'(1));
                n_state = (r_idx == pick_p1) ? S_A_WR : S_SHU_WR;
            end
            S_SHU_WR: begin
                we      = 1'b1;
                wa      = r_idx[IW-1:0];
                wd      = r_rd;
                n_idx   = r_idx - CW'(1);
                n_state = S_SHU_RD;
            end
            S_A_WR: begin
                we      = 1'b1;
                wa      = r_pick;
                wd.free = 1'b0;
                wd.size = r_split ? AW'(r_req.request_size) : r_pe.size;
                wd.addr = r_pe.addr;
                n_res.status         = ST_OK;
                n_res.granted_offset = pick_hdr[11:0];
                n_res.granted_size   = r_split ? r_req.request_size : 13'(SW'(r_pe.size));
                n_state = r_split ? S_A_WR2 : S_DONE;
            end
            S_A_WR2: begin
                we      = 1'b1;
                wa      = pick_p1[IW-1:0];
                wd.free = 1'b1;
                wd.size = AW'(SW'(r_pe.size) - need);
                wd.addr = AW'(pick_hdr + req_w);
                n_cnt   = r_cnt + CW'(1);
                n_state = S_DONE;
            end
            S_FN_RD: begin
                ra   = pick_p1[IW-1:0];
                n_nf = 1'b0;
                n_state = (pick_p1 < r_cnt) ? S_FN_CHK : S_FP_RD;
            end
            S_FN_CHK: begin
                n_nf    = r_rd.free;
                n_ne    = r_rd;
                n_state = S_FP_RD;
            end
            S_FP_RD: begin
                ra   = r_pick - IW'(1);
                n_pf = 1'b0;
                n_state = (r_pick != '0) ? S_FP_CHK : S_F_MRG;
            end
            S_FP_CHK: begin
                n_pf    = r_rd.free;
                n_pv    = r_rd;
                n_state = S_F_MRG;
            end
            S_F_MRG: begin
                we      = 1'b1;
                wd.free = 1'b1;
                if (r_pf) begin
                    wa      = r_pick - IW'(1);
                    wd.size = AW'(merged_p);
                    wd.addr = r_pv.addr;
                end else begin
                    wa      = r_pick;
                    wd.size = AW'(merged);
                    wd.addr = r_pe.addr;
                end
                n_rm    = {1'b0, r_nf} + {1'b0, r_pf};
                n_idx   = pick_p1 + CW'(r_nf);
                n_state = S_SHD_RD;
            end
            S_SHD_RD: begin
                if (r_idx >= r_cnt) begin
                    n_cnt   = r_cnt - CW'(r_rm);
                    n_res   = '{status: ST_OK, granted_offset: '0, granted_size: '0};
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHD_WR;
                end
            end
            S_SHD_WR: begin
                we      = 1'b1;
                wa      = IW'(r_idx - CW'(r_rm));
                wd      = r_rd;
                n_idx   = r_idx + CW'(1);
                n_state = S_SHD_RD;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= CW'(1);
            r_ov    <= 1'b0;
            r_fit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                r_fit <= i_cfg_data;
            end
        end
        r_idx   <= n_idx;
        r_pick  <= n_pick;
        r_rm    <= n_rm;
        r_found <= n_found;
        r_split <= n_split;
        r_nf    <= n_nf;
        r_pf    <= n_pf;
        r_req   <= n_req;
        r_pe    <= n_pe;
        r_ne    <= n_ne;
        r_pv    <= n_pv;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

FILE: sv/fha_checker.sv
// ----------------------------------------------------------------------------
// fha_checker
// Port-level checks on the allocator's request and result channels.
// ----------------------------------------------------------------------------
module fha_checker
    import fha_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK ||
                         o_out_data.status == ST_NO_FIT ||
                         o_out_data.status == ST_BAD_FREE))
        else $error("undefined status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.granted_offset == '0 && o_out_data.granted_size == '0)
        else $error("failed transaction carries data");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule

bind fit_heap_allocator fha_checker u_fha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: bench/tb_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_heap_allocator
// Drives allocate and free transactions with random idling on both sides,
// predicts every response from a behavioural block table kept here and
// checks responses in order, across first-fit and best-fit phases.
// ----------------------------------------------------------------------------
class heap_scoreboard;
    localparam int HEAP   = 4096;
    localparam int HDR    = 32;
    localparam int MAXBLK = 128;

    int unsigned blk_addr[MAXBLK];
    int unsigned blk_size[MAXBLK];
    bit          blk_free[MAXBLK];
    int unsigned nblk;
    bit          smallest_first;
    fha_pkg::t_rsp pending[$];
    int          errors;

    function void clear();
        nblk = 1;
        blk_addr[0] = 0;
        blk_size[0] = HEAP - HDR;
        blk_free[0] = 1;
        smallest_first = 0;
        pending.delete();
        errors = 0;
    endfunction

    function void shift_up(int unsigned pos);
        for (int unsigned k = nblk; k > pos; k--) begin
            blk_addr[k] = blk_addr[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
        end
        nblk++;
    endfunction

    function void shift_down(int unsigned pos);
        for (int unsigned k = pos; k + 1 < nblk; k++) begin
            blk_addr[k] = blk_addr[k+1];
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        nblk--;
    endfunction

    // live payload offsets, to aim frees at real blocks
    function int used_offset();
        int unsigned cand[$];
        for (int unsigned i = 0; i < nblk; i++)
            if (!blk_free[i]) cand.push_back(blk_addr[i] + HDR);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function void note_request(fha_pkg::t_req rq);
        fha_pkg::t_rsp r;
        int unsigned req, off, i, pick;
        bit found;
        r = '0;
        if (rq.operation == fha_pkg::OP_ALLOC) begin
            req = rq.request_size;
            found = 0;
            pick = 0;
            for (i = 0; i < nblk; i++) begin
                if (!blk_free[i] || blk_size[i] < req) continue;
                if (!smallest_first) begin
                    pick = i; found = 1; break;
                end
                if (!found || blk_size[i] < blk_size[pick]) begin
                    pick = i; found = 1;
                end
            end
            if (!found) begin
                r.status = fha_pkg::ST_NO_FIT;
            end else begin
                if (blk_size[pick] > req + HDR && nblk < MAXBLK) begin
                    shift_up(pick + 1);
                    blk_addr[pick+1] = blk_addr[pick] + HDR + req;
                    blk_size[pick+1] = blk_size[pick] - req - HDR;
                    blk_free[pick+1] = 1;
                    blk_size[pick] = req;
                end
                blk_free[pick] = 0;
                r.status = fha_pkg::ST_OK;
                r.granted_offset = 12'(blk_addr[pick] + HDR);
                r.granted_size = 13'(blk_size[pick]);
            end
        end else begin
            off = rq.payload_offset;
            for (i = 0; i < nblk; i++)
                if (!blk_free[i] && blk_addr[i] + HDR == off) break;
            if (i >= nblk) begin
                r.status = fha_pkg::ST_BAD_FREE;
            end else begin
                blk_free[i] = 1;
                if (i + 1 < nblk && blk_free[i+1]) begin
                    blk_size[i] += HDR + blk_size[i+1];
                    shift_down(i + 1);
                end
                if (i > 0 && blk_free[i-1]) begin
                    blk_size[i-1] += HDR + blk_size[i];
                    shift_down(i);
                end
                r.status = fha_pkg::ST_OK;
            end
        end
        pending.push_back(r);
    endfunction

    function void check_response(fha_pkg::t_rsp got);
        fha_pkg::t_rsp exp;
        if (pending.size() == 0) begin
            $error("unexpected response %p", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
        end
        if (got.granted_offset !== exp.granted_offset) begin
            $error("granted_offset: expected %0d, actual %0d",
                   exp.granted_offset, got.granted_offset);
            errors++;
        end
        if (got.granted_size !== exp.granted_size) begin
            $error("granted_size: expected %0d, actual %0d",
                   exp.granted_size, got.granted_size);
            errors++;
        end
    endfunction
endclass

module tb_fit_heap_allocator;
    import fha_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_rsp o_out_data;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic i_cfg_data = 0;

    heap_scoreboard board;
    int  cycles = 0;
    bit  calm = 0;
    int  hold_off = 0;

    fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fit_heap_allocator verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_response(o_out_data);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 12);
        end
    end

    // valid stays up after a transaction until the next one or an idle gap
    task automatic send(input t_req rq);
        bit idle;
        idle = !calm && ($urandom_range(99) < 12);
        if (idle) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < 12);
        end
        i_in_valid <= 1;
        i_in_data <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(rq);
    endtask

    task automatic send_alloc(input int unsigned sz);
        t_req rq;
        rq.operation = OP_ALLOC;
        rq.request_size = 13'(sz);
        rq.payload_offset = 12'($urandom);
        send(rq);
    endtask

    task automatic send_free(input int unsigned off);
        t_req rq;
        rq.operation = OP_FREE;
        rq.request_size = 13'($urandom);
        rq.payload_offset = 12'(off);
        send(rq);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.smallest_first = mode;
        i_cfg_valid <= 0;
    endtask

    task automatic random_item();
        int off;
        int unsigned r;
        r = $urandom_range(99);
        off = board.used_offset();
        if (r < 45 || off < 0 && r < 85) begin
            case ($urandom_range(9))
                0: send_alloc($urandom_range(8191));
                1: send_alloc($urandom_range(4096, 3000));
                2: send_alloc(0);
                default: send_alloc($urandom_range(200));
            endcase
        end else if (r < 85) begin
            send_free(off);
        end else begin
            send_free($urandom_range(4095));
        end
    endtask

    initial begin
        int off;
        board = new();
        board.clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send_alloc(4064);
        send_free(32);
        send_alloc(4065);
        send_alloc(8191);
        send_alloc(0);
        send_alloc(100);
        send_alloc(50);
        send_free(32 + 32);
        send_free(32 + 32);
        send_free(4095);
        send_free(0);
        send_alloc(40);
        send_alloc(4064);
        drain();
        // fill the table to exercise the unsplit grant
        for (int k = 0; k < 130; k++) send_alloc(0);
        send_alloc(4000);
        for (int k = 0; k < 40; k++) begin
            off = board.used_offset();
            if (off >= 0) send_free(off);
        end
        write_mode(1);
        send_alloc(10);
        send_alloc(1);
        send_alloc(10);

        // receiver holds off while the sender keeps offering
        hold_off <= 300;
        repeat (12) random_item();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            calm = (phase == 2);
            repeat (60) random_item();
        end

        calm = 0;
        drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("fit_heap_allocator verification clean");
        else
            $display("fit_heap_allocator verification failed");
        $finish;
    end
endmodule
